@@ design/affine_volume_trilinear_resampler_assert.svh @@
// Assertion macros used by the port checker of the resampler.
// Depends on nothing; take it in with a plain include.
`ifndef AFFINE_VOLUME_TRILINEAR_RESAMPLER_ASSERT_SVH
`define AFFINE_VOLUME_TRILINEAR_RESAMPLER_ASSERT_SVH

// Clocked property, masked while reset is asserted.
`define AVTR_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that also holds through reset.
`define AVTR_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/avtr_pkg.sv @@
// Package of the affine trilinear resampler: payload types, register indexes,
// reset values and default sizes. Depends on nothing.
package avtr_pkg;

    localparam int AVTR_MAX_DIM_X = 64;
    localparam int AVTR_MAX_DIM_Y = 64;
    localparam int AVTR_MAX_DIM_Z = 64;

    localparam int COORD_W = 10;
    localparam int VOX_W   = 8;
    localparam int DIM_W   = 7;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 3;

    typedef enum logic {
        OP_LOAD     = 1'b0,
        OP_RESAMPLE = 1'b1
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_X_IJ  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_X_KC  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_Y_IJ  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_Y_KC  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_Z_IJ  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_Z_KC  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_DIMS = 3'd6;

    localparam logic [CFG_W-1:0] RST_MAP_X_IJ = 64'h0000_0001_0000_0000;
    localparam logic [CFG_W-1:0] RST_MAP_X_KC = 64'h0;
    localparam logic [CFG_W-1:0] RST_MAP_Y_IJ = 64'h1;
    localparam logic [CFG_W-1:0] RST_MAP_Y_KC = 64'h0;
    localparam logic [CFG_W-1:0] RST_MAP_Z_IJ = 64'h0;
    localparam logic [CFG_W-1:0] RST_MAP_Z_KC = 64'h0000_0001_0000_0000;
    localparam logic [3*DIM_W-1:0] RST_INPUT_DIMS = 21'd1056832;

    typedef struct packed {
        op_t                operation;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_z;
        logic [VOX_W-1:0]   voxel_value;
    } avtr_in_t;

    typedef struct packed {
        logic [VOX_W-1:0] sample_value;
        logic             inside_res;
    } avtr_out_t;

endpackage

@@ design/avtr_voxel_bank.sv @@
// One voxel bank: simple dual-port memory, one write and one registered read.
// Depends on avtr_pkg for the voxel width.
module avtr_voxel_bank #(
    parameter int ADDR_W = 15
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic [avtr_pkg::VOX_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [ADDR_W-1:0]        rd_addr,
    output logic [avtr_pkg::VOX_W-1:0] rd_data_reg
);
    import avtr_pkg::*;

    logic [VOX_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

@@ design/affine_volume_trilinear_resampler.sv @@
// Affine trilinear resampler top level: address map, banked voxel store, blend.
// Depends on avtr_pkg and avtr_voxel_bank.
//
// Usage:
//  - s_ channel (valid/ready) carries one transaction per item: a load writes
//    one input voxel, a resample asks for one output voxel (i,j,k).
//  - m_ channel (valid/ready) returns one transaction per resample: the blended
//    intensity and the inside flag. Loads return nothing.
//  - cfg_we/cfg_index/cfg_wdata write the six map registers and input_dims;
//    write them only while no transaction is in flight.
//  - Nine register stages, the first loaded at the acceptance edge. Throughput:
//    one transaction per cycle unless m_ready stalls a full pipe; the store is
//    split into eight banks by the parity of x, y and z so all eight neighbours
//    are read in a single cycle.
//  - Loads write the store at the same stage where resamples read it, so the
//    order of transactions is kept exactly.
//  - Reset (aresetn low, synchronous) empties the pipe and restores the map
//    registers. The voxel store is not cleared; unwritten voxels read as junk.
//  - When m_ready is low the result holds; earlier stages keep filling their
//    empty slots, so s_ready only drops once every stage holds a transaction.
module affine_volume_trilinear_resampler #(
    parameter int MAX_DIM_X = avtr_pkg::AVTR_MAX_DIM_X,
    parameter int MAX_DIM_Y = avtr_pkg::AVTR_MAX_DIM_Y,
    parameter int MAX_DIM_Z = avtr_pkg::AVTR_MAX_DIM_Z
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  avtr_pkg::avtr_in_t                  s_payload,
    output logic                                m_valid,
    input  logic                                m_ready,
    output avtr_pkg::avtr_out_t                 m_payload,
    input  logic                                cfg_we,
    input  logic [avtr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [avtr_pkg::CFG_W-1:0]          cfg_wdata
);
    import avtr_pkg::*;

    // Bank geometry: each bank holds every second voxel on each axis.
    localparam int HX  = (MAX_DIM_X + 1) / 2;
    localparam int HY  = (MAX_DIM_Y + 1) / 2;
    localparam int HZ  = (MAX_DIM_Z + 1) / 2;
    localparam int XIW = (HX > 1) ? $clog2(HX) : 1;
    localparam int YIW = (HY > 1) ? $clog2(HY) : 1;
    localparam int ZIW = (HZ > 1) ? $clog2(HZ) : 1;
    localparam int ADDR_W = XIW + YIW + ZIW;
    localparam int NSTG = 9;

    localparam int PROD_W = 43;   // Q16.16 coefficient times 10-bit coordinate
    localparam int POS_W  = 46;   // sum of three products and an offset
    localparam int FR_W   = 16;
    localparam int WT_W   = 17;
    localparam int W2_W   = 33;
    localparam int W3_W   = 49;
    localparam int P_W    = 56;
    localparam int S_W    = 57;

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0]     map_reg [6];
    logic [3*DIM_W-1:0]   dims_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_reg[0] <= RST_MAP_X_IJ;
            map_reg[1] <= RST_MAP_X_KC;
            map_reg[2] <= RST_MAP_Y_IJ;
            map_reg[3] <= RST_MAP_Y_KC;
            map_reg[4] <= RST_MAP_Z_IJ;
            map_reg[5] <= RST_MAP_Z_KC;
            dims_reg   <= RST_INPUT_DIMS;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MAP_X_IJ:   map_reg[0] <= cfg_wdata;
                CFG_MAP_X_KC:   map_reg[1] <= cfg_wdata;
                CFG_MAP_Y_IJ:   map_reg[2] <= cfg_wdata;
                CFG_MAP_Y_KC:   map_reg[3] <= cfg_wdata;
                CFG_MAP_Z_IJ:   map_reg[4] <= cfg_wdata;
                CFG_MAP_Z_KC:   map_reg[5] <= cfg_wdata;
                CFG_INPUT_DIMS: dims_reg   <= cfg_wdata[3*DIM_W-1:0];
                default: ;      // unmapped index: dropped
            endcase
        end
    end

    // ---------------- stage valids and flow control ----------------
    // adv[k]: stage k may load this cycle (empty, or its item moves on).
    logic [NSTG:1] v_reg;
    logic [NSTG:1] v_next;
    logic [NSTG:1] adv;

    always_comb begin
        adv[NSTG] = !v_reg[NSTG] || m_ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign s_ready = adv[1];

    // ---------------- stage 1: coefficient products ----------------
    logic                        op1_reg;
    logic [COORD_W-1:0]          cx1_reg, cy1_reg, cz1_reg;
    logic [VOX_W-1:0]            val1_reg;
    logic signed [PROD_W-1:0]    pi1_reg [3], pj1_reg [3], pk1_reg [3];
    logic signed [PROD_W-1:0]    pi1_next [3], pj1_next [3], pk1_next [3];
    logic signed [COORD_W:0]     ci, cj, ck;

    always_comb begin
        ci = $signed({1'b0, s_payload.coord_x});
        cj = $signed({1'b0, s_payload.coord_y});
        ck = $signed({1'b0, s_payload.coord_z});
        for (int a = 0; a < 3; a++) begin
            pi1_next[a] = $signed(map_reg[2*a][63:32])   * ci;
            pj1_next[a] = $signed(map_reg[2*a][31:0])    * cj;
            pk1_next[a] = $signed(map_reg[2*a+1][63:32]) * ck;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            op1_reg  <= s_payload.operation;
            cx1_reg  <= s_payload.coord_x;
            cy1_reg  <= s_payload.coord_y;
            cz1_reg  <= s_payload.coord_z;
            val1_reg <= s_payload.voxel_value;
            pi1_reg  <= pi1_next;
            pj1_reg  <= pj1_next;
            pk1_reg  <= pk1_next;
        end
    end

    // ---------------- stage 2: positions ----------------
    logic                      op2_reg;
    logic [COORD_W-1:0]        cx2_reg, cy2_reg, cz2_reg;
    logic [VOX_W-1:0]          val2_reg;
    logic signed [POS_W-1:0]   p2_reg [3];
    logic signed [POS_W-1:0]   p2_next [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            p2_next[a] = POS_W'(pi1_reg[a]) + POS_W'(pj1_reg[a]) + POS_W'(pk1_reg[a])
                       + POS_W'($signed(map_reg[2*a+1][31:0]));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            op2_reg  <= op1_reg;
            cx2_reg  <= cx1_reg;
            cy2_reg  <= cy1_reg;
            cz2_reg  <= cz1_reg;
            val2_reg <= val1_reg;
            p2_reg   <= p2_next;
        end
    end

    // ---------------- stage 3: range check, split index/fraction ----------------
    localparam int MAXD [3] = '{MAX_DIM_X, MAX_DIM_Y, MAX_DIM_Z};

    logic                   op3_reg, in3_reg, wok3_reg;
    logic [COORD_W-1:0]     cx3_reg, cy3_reg, cz3_reg;
    logic [VOX_W-1:0]       val3_reg;
    logic [DIM_W-1:0]       base3_reg [3];
    logic [FR_W-1:0]        fr3_reg [3];
    logic                   in3_next, wok3_next;
    logic [DIM_W:0]         sz [3];
    logic [DIM_W+FR_W:0]    lim [3];

    always_comb begin
        in3_next = 1'b1;
        for (int a = 0; a < 3; a++) begin
            sz[a]  = ({1'b0, dims_reg[DIM_W*a +: DIM_W]} > (DIM_W+1)'(MAXD[a]))
                   ? (DIM_W+1)'(MAXD[a]) : {1'b0, dims_reg[DIM_W*a +: DIM_W]};
            lim[a] = {sz[a] - (DIM_W+1)'(1), {FR_W{1'b0}}};
            if (sz[a] < (DIM_W+1)'(2) || p2_reg[a][POS_W-1]
                || p2_reg[a][POS_W-2:0] >= (POS_W-1)'(lim[a])) begin
                in3_next = 1'b0;
            end
        end
        wok3_next = (cx2_reg < COORD_W'(MAX_DIM_X)) && (cy2_reg < COORD_W'(MAX_DIM_Y))
                 && (cz2_reg < COORD_W'(MAX_DIM_Z));
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            op3_reg  <= op2_reg;
            in3_reg  <= in3_next;
            wok3_reg <= wok3_next;
            cx3_reg  <= cx2_reg;
            cy3_reg  <= cy2_reg;
            cz3_reg  <= cz2_reg;
            val3_reg <= val2_reg;
            for (int a = 0; a < 3; a++) begin
                base3_reg[a] <= p2_reg[a][FR_W +: DIM_W];
                fr3_reg[a]   <= p2_reg[a][FR_W-1:0];
            end
        end
    end

    // ---------------- stage 4: banked store access ----------------
    // Bank id {px,py,pz}. For each axis a bank picks base or base+1,
    // whichever has its parity.
    logic [VOX_W-1:0] bank_rdata [8];
    logic             ld3;

    assign ld3 = v_reg[3] && (op3_reg == OP_LOAD) && wok3_reg;

    for (genvar b = 0; b < 8; b++) begin : g_bank
        localparam logic [2:0] BID = 3'(b);
        logic [DIM_W-1:0]  rx, ry, rz;
        logic [ADDR_W-1:0] raddr, waddr;
        logic              we;

        assign rx = (base3_reg[0][0] == BID[2]) ? base3_reg[0] : base3_reg[0] + DIM_W'(1);
        assign ry = (base3_reg[1][0] == BID[1]) ? base3_reg[1] : base3_reg[1] + DIM_W'(1);
        assign rz = (base3_reg[2][0] == BID[0]) ? base3_reg[2] : base3_reg[2] + DIM_W'(1);
        assign raddr = {rz[ZIW:1], ry[YIW:1], rx[XIW:1]};
        assign waddr = {cz3_reg[ZIW:1], cy3_reg[YIW:1], cx3_reg[XIW:1]};
        assign we    = adv[4] && ld3 && ({cx3_reg[0], cy3_reg[0], cz3_reg[0]} == BID);

        avtr_voxel_bank #(
            .ADDR_W (ADDR_W)
        ) u_bank (
            .aclk        (aclk),
            .wr_en       (we),
            .wr_addr     (waddr),
            .wr_data     (val3_reg),
            .rd_en       (adv[4]),
            .rd_addr     (raddr),
            .rd_data_reg (bank_rdata[b])
        );
    end

    logic              in4_reg;
    logic [2:0]        par4_reg;
    logic [FR_W-1:0]   fr4_reg [3];

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            in4_reg  <= in3_reg;
            par4_reg <= {base3_reg[0][0], base3_reg[1][0], base3_reg[2][0]};
            fr4_reg  <= fr3_reg;
        end
    end

    // ---------------- stage 5: xy weights, neighbour select ----------------
    logic              in5_reg;
    logic [W2_W-1:0]   wxy5_reg [4];
    logic [WT_W-1:0]   wz5_reg [2];
    logic [VOX_W-1:0]  d5_reg [8];
    logic [WT_W-1:0]   wx [2], wy [2], wz [2];
    logic [W2_W-1:0]   wxy5_next [4];
    logic [VOX_W-1:0]  d5_next [8];

    always_comb begin
        wx[0] = WT_W'(17'h10000) - WT_W'(fr4_reg[0]);
        wx[1] = WT_W'(fr4_reg[0]);
        wy[0] = WT_W'(17'h10000) - WT_W'(fr4_reg[1]);
        wy[1] = WT_W'(fr4_reg[1]);
        wz[0] = WT_W'(17'h10000) - WT_W'(fr4_reg[2]);
        wz[1] = WT_W'(fr4_reg[2]);
        for (int q = 0; q < 4; q++) begin
            wxy5_next[q] = W2_W'(wx[q>>1]) * W2_W'(wy[q&1]);
        end
        // neighbour c = {ox,oy,oz} lives in bank base parity xor offset
        for (int c = 0; c < 8; c++) begin
            d5_next[c] = bank_rdata[3'(c) ^ par4_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            in5_reg  <= in4_reg;
            wxy5_reg <= wxy5_next;
            wz5_reg  <= wz;
            d5_reg   <= d5_next;
        end
    end

    // ---------------- stage 6: full corner weights ----------------
    logic              in6_reg;
    logic [W3_W-1:0]   w6_reg [8];
    logic [VOX_W-1:0]  d6_reg [8];

    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            in6_reg <= in5_reg;
            d6_reg  <= d5_reg;
            for (int c = 0; c < 8; c++) begin
                w6_reg[c] <= W3_W'(wxy5_reg[c>>1]) * W3_W'(wz5_reg[c&1]);
            end
        end
    end

    // ---------------- stage 7: weighted voxels ----------------
    logic              in7_reg;
    logic [P_W-1:0]    pr7_reg [8];

    always_ff @(posedge aclk) begin
        if (adv[7]) begin
            in7_reg <= in6_reg;
            for (int c = 0; c < 8; c++) begin
                pr7_reg[c] <= P_W'(w6_reg[c]) * P_W'(d6_reg[c]);
            end
        end
    end

    // ---------------- stage 8: pair sums ----------------
    logic              in8_reg;
    logic [S_W-1:0]    ps8_reg [4];

    always_ff @(posedge aclk) begin
        if (adv[8]) begin
            in8_reg <= in7_reg;
            for (int q = 0; q < 4; q++) begin
                ps8_reg[q] <= S_W'(pr7_reg[2*q]) + S_W'(pr7_reg[2*q+1]);
            end
        end
    end

    // ---------------- stage 9: final sum, output register ----------------
    logic [S_W-1:0]    acc;
    avtr_out_t         out_reg;

    assign acc = ps8_reg[0] + ps8_reg[1] + ps8_reg[2] + ps8_reg[3];

    always_ff @(posedge aclk) begin
        if (adv[9]) begin
            out_reg.sample_value <= in8_reg ? acc[55:48] : '0;
            out_reg.inside_res   <= in8_reg;
        end
    end

    assign m_payload = out_reg;
    assign m_valid   = v_reg[NSTG];

    // ---------------- valid chain ----------------
    // Loads leave the pipe once they have written the store.
    always_comb begin
        v_next = v_reg;
        if (adv[1]) v_next[1] = s_valid;
        if (adv[2]) v_next[2] = v_reg[1];
        if (adv[3]) v_next[3] = v_reg[2];
        if (adv[4]) v_next[4] = v_reg[3] && (op3_reg == OP_RESAMPLE);
        for (int k = 5; k <= NSTG; k++) begin
            if (adv[k]) v_next[k] = v_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

endmodule

@@ design/avtr_port_checker.sv @@
// Port-level checker for the resampler, bound to the top level.
// Depends on avtr_pkg and the assertion macro header.
`include "affine_volume_trilinear_resampler_assert.svh"

module avtr_port_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input avtr_pkg::avtr_out_t  m_payload
);
    import avtr_pkg::*;

    `AVTR_ASSERT_RST(a_hold_valid, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result dropped while stalled")
    `AVTR_ASSERT_RST(a_hold_data, aclk, aresetn, m_valid && !m_ready |=> $stable(m_payload), "result changed while stalled")
    `AVTR_ASSERT_RST(a_outside_zero, aclk, aresetn, m_valid && !m_payload.inside_res |-> m_payload.sample_value == '0, "outside sample not zero")
    `AVTR_ASSERT_ALL(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind affine_volume_trilinear_resampler avtr_port_checker u_port_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

@@ test/avtr_sample_checker.sv @@
`timescale 1ns / 100ps
// Checker for the affine trilinear resampler: watches both channels and the
// config port, predicts each sample and compares it. Depends on avtr_pkg.
module avtr_sample_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  avtr_pkg::avtr_in_t             s_payload,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  avtr_pkg::avtr_out_t            m_payload,
    input  logic                           cfg_we,
    input  logic [avtr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [avtr_pkg::CFG_W-1:0]     cfg_wdata,
    output int                             fail_count,
    output int                             pending_samples,
    output int                             samples_seen,
    output int                             inside_seen
);
    import avtr_pkg::*;

    localparam int STORE_DEPTH = AVTR_MAX_DIM_X * AVTR_MAX_DIM_Y * AVTR_MAX_DIM_Z;

    logic [CFG_W-1:0] map_regs [0:6];
    bit   [VOX_W-1:0] volume [0:STORE_DEPTH-1];
    avtr_out_t        expected_samples [$];
    int               errs;
    int               n_samples;
    int               n_inside;

    assign fail_count = errs;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] sample mismatch on %s: got %0d, expected %0d", $realtime, what,
                 got, want);
        errs++;
    endtask

    function automatic int vox_addr(input int x, input int y, input int z);
        return (z * AVTR_MAX_DIM_Y + y) * AVTR_MAX_DIM_X + x;
    endfunction

    function automatic int dim_of(input int axis);
        int s;
        int cap;
        s   = int'(map_regs[CFG_INPUT_DIMS][axis*DIM_W +: DIM_W]);
        cap = (axis == 0) ? AVTR_MAX_DIM_X : (axis == 1) ? AVTR_MAX_DIM_Y : AVTR_MAX_DIM_Z;
        return (s > cap) ? cap : s;
    endfunction

    // Q16.16 position on one axis, exact in 64 bits.
    function automatic longint axis_pos(input int axis, input avtr_in_t it);
        logic [CFG_W-1:0] ij;
        logic [CFG_W-1:0] kc;
        ij = map_regs[2*axis];
        kc = map_regs[2*axis+1];
        return longint'($signed(ij[63:32])) * longint'(it.coord_x)
             + longint'($signed(ij[31:0]))  * longint'(it.coord_y)
             + longint'($signed(kc[63:32])) * longint'(it.coord_z)
             + longint'($signed(kc[31:0]));
    endfunction

    function automatic avtr_out_t blend_sample(input avtr_in_t it);
        avtr_out_t   r;
        longint      p;
        int          base [3];
        longint unsigned frac [3];
        longint unsigned acc;
        longint unsigned w;
        int          sz;
        r   = '0;
        acc = 0;
        for (int a = 0; a < 3; a++) begin
            p  = axis_pos(a, it);
            sz = dim_of(a);
            if (sz < 2 || p < 0 || p >= longint'(sz - 1) * 65536)
                return r;
            base[a] = int'(p >>> 16);
            frac[a] = longint'(p) & 64'hFFFF;
        end
        for (int c = 0; c < 8; c++) begin
            w = ((c & 4) ? frac[0] : 65536 - frac[0])
              * ((c & 2) ? frac[1] : 65536 - frac[1])
              * ((c & 1) ? frac[2] : 65536 - frac[2]);
            acc += w * volume[vox_addr(base[0] + ((c >> 2) & 1), base[1] + ((c >> 1) & 1),
                                       base[2] + (c & 1))];
        end
        r.sample_value = acc[55:48];
        r.inside_res   = 1'b1;
        return r;
    endfunction

    initial begin
        errs = 0;
        n_samples = 0;
        n_inside = 0;
        pending_samples = 0;
        samples_seen = 0;
        inside_seen = 0;
    end

    always @(posedge aclk) begin
        avtr_out_t want;
        if (!aresetn) begin
            map_regs[CFG_MAP_X_IJ]   = RST_MAP_X_IJ;
            map_regs[CFG_MAP_X_KC]   = RST_MAP_X_KC;
            map_regs[CFG_MAP_Y_IJ]   = RST_MAP_Y_IJ;
            map_regs[CFG_MAP_Y_KC]   = RST_MAP_Y_KC;
            map_regs[CFG_MAP_Z_IJ]   = RST_MAP_Z_IJ;
            map_regs[CFG_MAP_Z_KC]   = RST_MAP_Z_KC;
            map_regs[CFG_INPUT_DIMS] = CFG_W'(RST_INPUT_DIMS);
            expected_samples.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_INPUT_DIMS)
                    map_regs[cfg_index] = cfg_wdata & 64'h1F_FFFF;
                else if (cfg_index < CFG_INPUT_DIMS)
                    map_regs[cfg_index] = cfg_wdata;
            end
            if (s_valid && s_ready) begin
                if (s_payload.operation == OP_LOAD) begin
                    if (s_payload.coord_x < AVTR_MAX_DIM_X && s_payload.coord_y < AVTR_MAX_DIM_Y
                        && s_payload.coord_z < AVTR_MAX_DIM_Z)
                        volume[vox_addr(s_payload.coord_x, s_payload.coord_y,
                                        s_payload.coord_z)] = s_payload.voxel_value;
                end else begin
                    expected_samples.push_back(blend_sample(s_payload));
                end
            end
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch("unexpected transaction", 1, 0);
                end else begin
                    want = expected_samples.pop_front();
                    n_samples++;
                    if (want.inside_res)
                        n_inside++;
                    if (m_payload.sample_value !== want.sample_value)
                        report_mismatch("sample_value", m_payload.sample_value,
                                        want.sample_value);
                    if (m_payload.inside_res !== want.inside_res)
                        report_mismatch("inside_res", m_payload.inside_res, want.inside_res);
                end
            end
        end
        pending_samples <= expected_samples.size();
        samples_seen    <= n_samples;
        inside_seen     <= n_inside;
    end

endmodule

@@ test/tb_affine_volume_trilinear_resampler.sv @@
`timescale 1ns / 100ps
// Testbench top for the affine trilinear resampler: clock, reset, stimulus,
// config phases and verdict. Depends on avtr_pkg and avtr_sample_checker.
module tb_affine_volume_trilinear_resampler;
    import avtr_pkg::*;

    localparam int LATENCY     = 9;
    localparam int CYCLE_LIMIT = 400000;
    localparam int STORE_DEPTH = AVTR_MAX_DIM_X * AVTR_MAX_DIM_Y * AVTR_MAX_DIM_Z;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    avtr_in_t             s_payload = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    avtr_out_t            m_payload;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    int fail_count;
    int pending_samples;
    int samples_seen;
    int inside_seen;

    // Idle percentages per side, long-hold handshake between stimulus and receiver.
    int send_idle = 0;
    int recv_idle = 0;
    int hold_req  = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycles    = 0;
    int items_sent = 0;

    // Stimulus-side view of the map and of which voxels hold data, so that no
    // resample ever reads a voxel that was never loaded.
    logic [CFG_W-1:0] cur_map [0:6];
    bit               loaded [0:STORE_DEPTH-1];

    always #4 aclk = ~aclk;

    affine_volume_trilinear_resampler dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    avtr_sample_checker u_sample_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending_samples(pending_samples),
        .samples_seen(samples_seen), .inside_seen(inside_seen)
    );

    // Watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d samples outstanding", cycles,
                     pending_samples);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold when the stimulus asks for one.
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // One transaction on the input channel; valid stays up across back-to-back items.
    task automatic send_item(input avtr_in_t it);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (it.operation == OP_LOAD && it.coord_x < AVTR_MAX_DIM_X
            && it.coord_y < AVTR_MAX_DIM_Y && it.coord_z < AVTR_MAX_DIM_Z)
            loaded[(it.coord_z * AVTR_MAX_DIM_Y + it.coord_y) * AVTR_MAX_DIM_X
                   + it.coord_x] = 1'b1;
    endtask

    // Quiet point: every sample back, then enough cycles for trailing loads.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_samples != 0)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_map(input logic [CFG_W-1:0] regs [0:6]);
        drain();
        for (int r = 0; r <= int'(CFG_INPUT_DIMS); r++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(r);
            cfg_wdata <= regs[r];
            cur_map[r] = (r == int'(CFG_INPUT_DIMS)) ? (regs[r] & 64'h1F_FFFF) : regs[r];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    // True when the item is a load, maps outside, or all eight neighbours hold data.
    function automatic bit reads_loaded(input avtr_in_t it);
        longint p;
        int     b [3];
        int     sz;
        int     cap;
        if (it.operation == OP_LOAD)
            return 1'b1;
        for (int a = 0; a < 3; a++) begin
            p = longint'($signed(cur_map[2*a][63:32])) * longint'(it.coord_x)
              + longint'($signed(cur_map[2*a][31:0])) * longint'(it.coord_y)
              + longint'($signed(cur_map[2*a+1][63:32])) * longint'(it.coord_z)
              + longint'($signed(cur_map[2*a+1][31:0]));
            sz  = int'(cur_map[CFG_INPUT_DIMS][a*DIM_W +: DIM_W]);
            cap = (a == 0) ? AVTR_MAX_DIM_X : (a == 1) ? AVTR_MAX_DIM_Y : AVTR_MAX_DIM_Z;
            if (sz > cap)
                sz = cap;
            if (sz < 2 || p < 0 || p >= longint'(sz - 1) * 65536)
                return 1'b1;
            b[a] = int'(p >>> 16);
        end
        for (int c = 0; c < 8; c++)
            if (!loaded[((b[2] + (c & 1)) * AVTR_MAX_DIM_Y + b[1] + ((c >> 1) & 1))
                        * AVTR_MAX_DIM_X + b[0] + ((c >> 2) & 1)])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic avtr_in_t mk_item(input op_t op, input int x, input int y,
                                         input int z, input int v);
        avtr_in_t it;
        it.operation   = op;
        it.coord_x     = COORD_W'(x);
        it.coord_y     = COORD_W'(y);
        it.coord_z     = COORD_W'(z);
        it.voxel_value = VOX_W'(v);
        return it;
    endfunction

    function automatic logic [CFG_W-1:0] pair(input int hi, input int lo);
        return {hi[31:0], lo[31:0]};
    endfunction

    function automatic logic [CFG_W-1:0] dims(input int x, input int y, input int z);
        return CFG_W'({z[6:0], y[6:0], x[6:0]});
    endfunction

    function automatic int cross_term();
        return int'($urandom_range(0, 32'h6000)) - 32'h3000;
    endfunction

    // Random mix: loads into the filled block and row, stray loads, and resamples
    // near the origin with a few full-range coordinates.
    function automatic avtr_in_t rand_item(input int i_max);
        avtr_in_t it;
        int       r;
        r = $urandom_range(99);
        if (r < 12)
            return mk_item(OP_LOAD, $urandom_range(15), $urandom_range(3), $urandom_range(3),
                           $urandom_range(255));
        if (r < 18)
            return mk_item(OP_LOAD, $urandom_range(63), $urandom_range(1), $urandom_range(1),
                           $urandom_range(255));
        if (r < 22)
            return mk_item(OP_LOAD, $urandom_range(1023), $urandom_range(1023),
                           $urandom_range(1023), $urandom_range(255));
        for (int t = 0; t < 6; t++) begin
            if ($urandom_range(99) < 85)
                it = mk_item(OP_RESAMPLE, $urandom_range(i_max), $urandom_range(5),
                             $urandom_range(5), $urandom_range(255));
            else
                it = mk_item(OP_RESAMPLE, $urandom_range(1023), $urandom_range(1023),
                             $urandom_range(1023), $urandom_range(255));
            if (reads_loaded(it))
                return it;
        end
        return mk_item(OP_LOAD, $urandom_range(15), $urandom_range(3), $urandom_range(3),
                       $urandom_range(255));
    endfunction

    task automatic send_checked(input avtr_in_t it);
        if (reads_loaded(it))
            send_item(it);
    endtask

    initial begin
        logic [CFG_W-1:0] regs [0:6];
        int               i_max;
        int               total;

        cur_map[CFG_MAP_X_IJ]   = RST_MAP_X_IJ;
        cur_map[CFG_MAP_X_KC]   = RST_MAP_X_KC;
        cur_map[CFG_MAP_Y_IJ]   = RST_MAP_Y_IJ;
        cur_map[CFG_MAP_Y_KC]   = RST_MAP_Y_KC;
        cur_map[CFG_MAP_Z_IJ]   = RST_MAP_Z_IJ;
        cur_map[CFG_MAP_Z_KC]   = RST_MAP_Z_KC;
        cur_map[CFG_INPUT_DIMS] = CFG_W'(RST_INPUT_DIMS);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset map: corner cube with extreme intensities,
        // out-of-range loads that must be dropped, then resamples on and off the volume.
        for (int c = 0; c < 8; c++)
            send_item(mk_item(OP_LOAD, (c >> 2) & 1, (c >> 1) & 1, c & 1,
                              (c == 0) ? 255 : (c == 7) ? 0 : c * 37));
        send_item(mk_item(OP_LOAD, 1023, 1023, 1023, 8'hAA));
        send_item(mk_item(OP_LOAD, AVTR_MAX_DIM_X, 0, 0, 8'h55));
        send_item(mk_item(OP_LOAD, 0, 0, AVTR_MAX_DIM_Z, 8'h11));
        send_checked(mk_item(OP_RESAMPLE, 0, 0, 0, 255));
        send_checked(mk_item(OP_RESAMPLE, 0, 1023, 0, 0));
        send_checked(mk_item(OP_RESAMPLE, 0, 40000 / 40, 0, 0));
        send_checked(mk_item(OP_RESAMPLE, 1023, 0, 0, 0));
        send_checked(mk_item(OP_RESAMPLE, 63, 0, 0, 0));
        send_checked(mk_item(OP_RESAMPLE, 0, 0, 1023, 0));
        send_checked(mk_item(OP_RESAMPLE, 1023, 1023, 1023, 255));

        // Fill a 16x4x4 block and a full-length row along x.
        send_idle = 23;
        recv_idle = 66;
        for (int z = 0; z < 4; z++)
            for (int y = 0; y < 4; y++)
                for (int x = 0; x < ((y < 2 && z < 2) ? 64 : 16); x++)
                    send_item(mk_item(OP_LOAD, x, y, z, $urandom_range(255)));

        for (int ph = 0; ph < 6; ph++) begin
            i_max = 17;
            case (ph)
                0: begin
                    // Unit steps with fractional offsets.
                    regs[CFG_MAP_X_IJ]   = pair(32'h1_0000, 0);
                    regs[CFG_MAP_X_KC]   = pair(0, $urandom_range(32'hFFFF));
                    regs[CFG_MAP_Y_IJ]   = pair(0, 32'h1_0000);
                    regs[CFG_MAP_Y_KC]   = pair(0, $urandom_range(32'hFFFF));
                    regs[CFG_MAP_Z_IJ]   = pair(0, 0);
                    regs[CFG_MAP_Z_KC]   = pair(32'h1_0000, $urandom_range(32'hFFFF));
                    regs[CFG_INPUT_DIMS] = dims(16, 4, 4);
                end
                2: begin
                    // Extreme words; every axis size out of reach or clamped.
                    regs[CFG_MAP_X_IJ]   = 64'hFFFF_FFFF_FFFF_FFFF;
                    regs[CFG_MAP_X_KC]   = 64'h7FFF_FFFF_8000_0000;
                    regs[CFG_MAP_Y_IJ]   = 64'h8000_0000_7FFF_FFFF;
                    regs[CFG_MAP_Y_KC]   = 64'h0;
                    regs[CFG_MAP_Z_IJ]   = 64'hFFFF_FFFF_FFFF_FFFF;
                    regs[CFG_MAP_Z_KC]   = 64'hFFFF_FFFF_FFFF_FFFF;
                    regs[CFG_INPUT_DIMS] = 64'hFFFF_FFFF_FFFF_FFFF;
                end
                3: begin
                    // Half steps along x over a size of 127, clamped to 64; y and z fixed
                    // inside the first cell of the filled row.
                    i_max = 130;
                    regs[CFG_MAP_X_IJ]   = pair(32'h8000, cross_term() / 8);
                    regs[CFG_MAP_X_KC]   = pair(0, $urandom_range(32'hFFFF));
                    regs[CFG_MAP_Y_IJ]   = pair(0, 0);
                    regs[CFG_MAP_Y_KC]   = pair(0, $urandom_range(32'hFFFF));
                    regs[CFG_MAP_Z_IJ]   = pair(0, 0);
                    regs[CFG_MAP_Z_KC]   = pair(0, $urandom_range(32'hFFFF));
                    regs[CFG_INPUT_DIMS] = dims(127, 2, 2);
                end
                default: begin
                    // Random gains with small shears, sizes from zero upward.
                    regs[CFG_MAP_X_IJ]   = pair($urandom_range(32'h4000, 32'h1_8000),
                                                cross_term());
                    regs[CFG_MAP_X_KC]   = pair(cross_term(), $urandom_range(32'h2_0000));
                    regs[CFG_MAP_Y_IJ]   = pair(cross_term(),
                                                $urandom_range(32'h4000, 32'h1_4000));
                    regs[CFG_MAP_Y_KC]   = pair(cross_term(), $urandom_range(32'h1_8000));
                    regs[CFG_MAP_Z_IJ]   = pair(cross_term(), cross_term());
                    regs[CFG_MAP_Z_KC]   = pair($urandom_range(32'h4000, 32'h1_4000),
                                                $urandom_range(32'h1_8000)
                                                - ((ph == 5) ? 32'h8000 : 0));
                    regs[CFG_INPUT_DIMS] = dims((ph == 4) ? 1 : $urandom_range(2, 16),
                                                $urandom_range(2, 4),
                                                (ph == 5) ? 0 : $urandom_range(2, 4));
                    if (ph == 1)
                        regs[CFG_INPUT_DIMS] = dims($urandom_range(2, 16),
                                                    $urandom_range(2, 4),
                                                    $urandom_range(2, 4));
                end
            endcase
            // Phases 4 and 5 reuse random setups with an axis size below two, so all samples
            // are outside; phase 4 gets a second, inside-friendly setup half way through.
            send_idle = (ph < 2) ? 23 : (ph < 4) ? 66 : 0;
            recv_idle = (ph < 2) ? 66 : (ph < 4) ? 23 : 0;
            write_map(regs);
            total = 230;
            for (int n = 0; n < total; n++) begin
                if (ph == 1 && n == total / 2)
                    drain();
                if (ph == 4 && n == 20)
                    hold_req = hold_req + 1;
                if (ph == 4 && n == total / 2) begin
                    regs[CFG_INPUT_DIMS] = dims(16, 4, 4);
                    write_map(regs);
                end
                send_item(rand_item(i_max));
            end
        end

        drain();
        $display("%0d items sent, %0d samples checked (%0d inside) over 8 map setups",
                 items_sent, samples_seen, inside_seen);
        $display("stall patterns: sender-heavy, receiver-heavy, none, one 300-cycle hold");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/avtr_pkg.sv
design/avtr_voxel_bank.sv
design/affine_volume_trilinear_resampler.sv
design/avtr_port_checker.sv
test/avtr_sample_checker.sv
test/tb_affine_volume_trilinear_resampler.sv
